// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL files of the decrypt stream.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define VDS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition never holds outside reset.
`define VDS_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== hdl/vds_pkg.sv =====
// ----------------------------------------------------------------------------
// vds_pkg
// Types, constants and helper functions of the Vigenere decrypt stream.
// ----------------------------------------------------------------------------
`default_nettype none

package vds_pkg;

  localparam int unsigned MAX_KEY_LETTERS = 16;
  localparam int unsigned POS_W           = $clog2(MAX_KEY_LETTERS);
  localparam int unsigned KEY_LEN_W       = 5;
  localparam int unsigned KEY_BITS        = 8 * MAX_KEY_LETTERS;
  localparam int unsigned CFG_DATA_W      = 64;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned SHIFT_W         = 5;

  localparam logic [7:0]         CHAR_UPPER_A = 8'd65;
  localparam logic [7:0]         CHAR_UPPER_Z = 8'd90;
  localparam logic [7:0]         CHAR_LOWER_A = 8'd97;
  localparam logic [7:0]         CHAR_LOWER_Z = 8'd122;
  localparam logic [5:0]         ALPHA_LEN    = 6'd26;

  localparam logic [KEY_LEN_W-1:0]  KEY_LEN_RESET   = KEY_LEN_W'(1);
  localparam logic [CFG_DATA_W-1:0] KEY_CHARS_RESET = 64'h4141_4141_4141_4141;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LENGTH = 2'd0,
    CFG_KEY_LOW    = 2'd1,
    CFG_KEY_HIGH   = 2'd2
  } vds_cfg_e;

  // Key setup seen by the front end.
  typedef struct packed {
    logic [KEY_LEN_W-1:0] key_length;
    logic [KEY_BITS-1:0]  key_chars;
  } vds_key_cfg_t;

  // One classified beat, front end to back end.
  typedef struct packed {
    logic [7:0]         ch;
    logic               eom;
    logic               letter;
    logic               upper;
    logic [SHIFT_W-1:0] shift;
  } vds_entry_t;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z);
  endfunction

  // Alphabet position of a keyword byte; non-letters give zero.
  function automatic logic [SHIFT_W-1:0] shift_of(input logic [7:0] k);
    logic [7:0] diff;
    diff = '0;
    if (is_upper(k)) begin
      diff = k - CHAR_UPPER_A;
    end else if (is_lower(k)) begin
      diff = k - CHAR_LOWER_A;
    end
    return diff[SHIFT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/vds_in_if.sv =====
// ----------------------------------------------------------------------------
// vds_in_if
// Ciphertext channel: valid/ready handshake carrying one byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface vds_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] cipher_char;
  logic       end_of_message;

  modport source (output valid, output cipher_char, output end_of_message, input ready);
  modport sink   (input valid, input cipher_char, input end_of_message, output ready);
endinterface

`default_nettype wire

// ===== hdl/vds_out_if.sv =====
// ----------------------------------------------------------------------------
// vds_out_if
// Plaintext channel: valid/ready handshake carrying one byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface vds_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] plain_char;
  logic       message_done;

  modport source (output valid, output plain_char, output message_done, input ready);
  modport sink   (input valid, input plain_char, input message_done, output ready);
endinterface

`default_nettype wire

// ===== hdl/vds_front.sv =====
// ----------------------------------------------------------------------------
// vds_front
// Accepts ciphertext beats, classifies them and tracks the key position.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module vds_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire vds_pkg::vds_key_cfg_t key_cfg_i,
  vds_in_if.sink                     in_i,
  input  wire logic                  full_i,
  output logic                       push_o,
  output vds_pkg::vds_entry_t        entry_o
);
  import vds_pkg::*;

  logic [POS_W-1:0]     pos_q, pos_d;
  logic [POS_W-1:0]     pos_eff;
  logic [POS_W:0]       pos_inc;
  logic [KEY_LEN_W-1:0] len;
  logic [7:0]           key_byte;
  logic                 up, lo, letter;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    if (key_cfg_i.key_length == '0) begin
      len = KEY_LEN_W'(1);
    end else if (key_cfg_i.key_length > KEY_LEN_W'(MAX_KEY_LETTERS)) begin
      len = KEY_LEN_W'(MAX_KEY_LETTERS);
    end else begin
      len = key_cfg_i.key_length;
    end
  end

  // a position left stale by a shorter key restarts at byte 0
  assign pos_eff  = ({1'b0, pos_q} >= len) ? '0 : pos_q;
  assign key_byte = key_cfg_i.key_chars[{pos_eff, 3'b000} +: 8];
  assign up       = is_upper(in_i.cipher_char);
  assign lo       = is_lower(in_i.cipher_char);
  assign letter   = up || lo;
  assign pos_inc  = {1'b0, pos_eff} + (POS_W+1)'(1);

  always_comb begin
    pos_d = pos_eff;
    if (letter) begin
      pos_d = (pos_inc >= len) ? '0 : pos_inc[POS_W-1:0];
    end
    if (in_i.end_of_message) begin
      pos_d = '0;
    end
  end

  always_comb begin
    entry_o.ch     = in_i.cipher_char;
    entry_o.eom    = in_i.end_of_message;
    entry_o.letter = letter;
    entry_o.upper  = up;
    entry_o.shift  = shift_of(key_byte);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (push_o) begin
      pos_q <= pos_d;
    end
  end

  `VDS_ASSERT(a_eom_restarts_key, clk_i, rst_ni,
    push_o && in_i.end_of_message |=> pos_q == '0, "key position not cleared after end of message")

endmodule

`default_nettype wire

// ===== hdl/vds_queue.sv =====
// ----------------------------------------------------------------------------
// vds_queue
// Short FIFO of classified beats between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module vds_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire vds_pkg::vds_entry_t push_entry_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output logic                     empty_o,
  output vds_pkg::vds_entry_t      head_o
);
  import vds_pkg::*;

  vds_entry_t          mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_AW:0]   count_q;

  assign full_o  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + (QUEUE_AW+1)'(1);
        2'b01:   count_q <= count_q - (QUEUE_AW+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  `VDS_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o, "push into full queue")
  `VDS_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && empty_o, "pop from empty queue")

endmodule

`default_nettype wire

// ===== hdl/vds_back.sv =====
// ----------------------------------------------------------------------------
// vds_back
// Shifts letters back by the key shift and holds the result for output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module vds_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                empty_i,
  input  wire vds_pkg::vds_entry_t head_i,
  output logic                     pop_o,
  vds_out_if.source                out_o
);
  import vds_pkg::*;

  logic               out_valid_q;
  logic [7:0]         plain_q, plain_d;
  logic               done_q;
  logic [7:0]         base;
  logic [7:0]         diff;
  logic [SHIFT_W-1:0] off, off_n;
  logic [5:0]         wrapped;

  assign pop_o = !empty_i && (!out_valid_q || out_o.ready);

  assign base    = head_i.upper ? CHAR_UPPER_A : CHAR_LOWER_A;
  assign diff    = head_i.ch - base;
  assign off     = diff[SHIFT_W-1:0];
  assign wrapped = {1'b0, off} + ALPHA_LEN - {1'b0, head_i.shift};
  assign off_n   = (off >= head_i.shift) ? (off - head_i.shift) : wrapped[SHIFT_W-1:0];
  assign plain_d = head_i.letter ? (base + {3'b000, off_n}) : head_i.ch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      plain_q <= plain_d;
      done_q  <= head_i.eom;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.plain_char   = plain_q;
  assign out_o.message_done = done_q;

  `VDS_ASSERT(a_pop_loads_output, clk_i, rst_ni, pop_o |=> out_valid_q,
    "popped beat did not reach output register")

endmodule

`default_nettype wire

// ===== hdl/vigenere_decrypt_stream.sv =====
// ----------------------------------------------------------------------------
// vigenere_decrypt_stream
// Streaming Vigenere decryption of ASCII bytes with a keyword of up to
// sixteen letters.
// ----------------------------------------------------------------------------
// One ciphertext beat in gives one plaintext beat out, in order. The block
// takes a new beat every cycle while in_i.ready is high; an accepted beat is
// written into the queue and from there into the output register on out_o;
// throughput is one beat per cycle as long as the output side keeps taking
// beats. The front end picks the key byte at
// the current key position and advances the position, a two-entry queue
// decouples it from the back end, and the back end does the subtract-and-wrap
// into an output register. When the output stalls, the queue and the output
// register absorb three beats before in_i.ready drops. Letters are shifted
// back inside their own case; other bytes pass unchanged and do not advance
// the key. The key position returns to zero after a beat flagged end of
// message. Key length 0 acts as 1, lengths above 16 as 16, non-letter
// keyword bytes as shift 0. Reset key: length 1, all 'A' (pass-through).
// Write configuration only when no beat is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module vigenere_decrypt_stream (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [vds_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [vds_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  vds_in_if.sink                                in_i,
  vds_out_if.source                             out_o
);
  import vds_pkg::*;

  // configuration registers
  logic [KEY_LEN_W-1:0]  key_len_q;
  logic [CFG_DATA_W-1:0] key_low_q;
  logic [CFG_DATA_W-1:0] key_high_q;
  vds_key_cfg_t          key_cfg;

  // front end to queue
  logic       push;
  logic       full;
  vds_entry_t push_entry;

  // queue to back end
  logic       pop;
  logic       empty;
  vds_entry_t head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q  <= KEY_LEN_RESET;
      key_low_q  <= KEY_CHARS_RESET;
      key_high_q <= KEY_CHARS_RESET;
    end else if (cfg_we_i) begin
      unique case (vds_cfg_e'(cfg_idx_i))
        CFG_KEY_LENGTH: key_len_q  <= cfg_wdata_i[KEY_LEN_W-1:0];
        CFG_KEY_LOW:    key_low_q  <= cfg_wdata_i;
        CFG_KEY_HIGH:   key_high_q <= cfg_wdata_i;
        default:        ; // unused index, write dropped
      endcase
    end
  end

  assign key_cfg.key_length = key_len_q;
  assign key_cfg.key_chars  = {key_high_q, key_low_q};  // byte 0 in bits 7:0

  // front end: classify the beat, pick its key shift, step the key position
  vds_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .key_cfg_i (key_cfg),
    .in_i      (in_i),
    .full_i    (full),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  // decoupling queue
  vds_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .empty_o      (empty),
    .head_o       (head)
  );

  // back end: subtract and wrap, output register
  vds_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming Vigenere decryptor: queued ciphertext
// beats, a shadow key and key position predicting each plaintext beat, and
// random burst gaps and output stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  import vds_pkg::*;

  // Cycles with no beat on either channel before the run is called hung.
  // The longest legal quiet stretch is the forced output hold plus a sender
  // gap and the pipeline depth, so this leaves a wide margin.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_BEATS   = 1150;
  localparam int unsigned HOLD_CYCLES    = 150;
  localparam int unsigned PIPE_SETTLE    = 4;

  typedef struct packed {
    logic [7:0] ch;
    logic       eom;
  } cipher_beat_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       done;
  } plain_beat_t;

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_PATTERN,
    RX_RANDOM
  } rx_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  vds_in_if  cipher_if ();
  vds_out_if plain_if ();

  vigenere_decrypt_stream uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (cipher_if),
    .out_o       (plain_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow of the block: key registers as last written, and the key position
  // that walks along the keyword as letters go by.
  // --------------------------------------------------------------------------
  logic [KEY_LEN_W-1:0]  key_len_q;
  logic [CFG_DATA_W-1:0] key_lo_q;
  logic [CFG_DATA_W-1:0] key_hi_q;
  logic [POS_W-1:0]      key_pos_q;

  cipher_beat_t cipher_q[$];     // ciphertext waiting to be offered
  plain_beat_t  plaintext_q[$];  // plaintext owed by the block, oldest first

  int unsigned fail_count = 0;

  // Decrypt one beat against the shadow key and advance the key position.
  function automatic plain_beat_t decrypt_beat(input logic [7:0] c, input logic eom);
    int unsigned              len;
    int unsigned              pos;
    int unsigned              shift;
    int unsigned              off;
    logic [7:0]               base;
    logic [7:0]               kch;
    logic [8*MAX_KEY_LETTERS-1:0] keyword;
    plain_beat_t              res;
    len = key_len_q;
    if (len == 0) begin
      len = 1;                         // zero length acts as one
    end else if (len > MAX_KEY_LETTERS) begin
      len = MAX_KEY_LETTERS;           // saturate long lengths
    end
    pos = key_pos_q;
    if (pos >= len) begin
      pos = 0;                         // length was lowered under us
    end
    res.ch   = c;
    res.done = eom;
    if ((c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
        (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)) begin
      base    = (c <= CHAR_UPPER_Z) ? CHAR_UPPER_A : CHAR_LOWER_A;
      keyword = {key_hi_q, key_lo_q};
      kch     = keyword[pos*8 +: 8];
      if (kch >= CHAR_UPPER_A && kch <= CHAR_UPPER_Z) begin
        shift = kch - CHAR_UPPER_A;
      end else if (kch >= CHAR_LOWER_A && kch <= CHAR_LOWER_Z) begin
        shift = kch - CHAR_LOWER_A;
      end else begin
        shift = 0;                     // non-letter key byte
      end
      off    = c - base;
      off    = (off >= shift) ? off - shift : off + ALPHA_LEN - shift;
      res.ch = base + 8'(off);
      pos    = pos + 1;
      if (pos >= len) begin
        pos = 0;
      end
    end
    if (eom) begin
      pos = 0;
    end
    key_pos_q = POS_W'(pos);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Ciphertext driver: bursts of random length split by random gaps. A beat
  // on offer stays put until the block takes it.
  // --------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cipher_if.valid <= 1'b0;
    end else begin
      if (cipher_if.valid && cipher_if.ready) begin
        // Predict on acceptance so the shadow key position follows the
        // exact order the block sees.
        plaintext_q.push_back(decrypt_beat(cipher_if.cipher_char,
                                           cipher_if.end_of_message));
        void'(cipher_q.pop_front());
      end
      if (cipher_if.valid && !cipher_if.ready) begin
        // stalled: hold the beat
      end else if (gap_left != 0) begin
        gap_left--;
        cipher_if.valid <= 1'b0;
      end else if (cipher_q.size() != 0) begin
        cipher_if.valid          <= 1'b1;
        cipher_if.cipher_char    <= cipher_q[0].ch;
        cipher_if.end_of_message <= cipher_q[0].eom;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 32);
          // a quarter of bursts run straight into the next one
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        cipher_if.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Plaintext monitor and receiver. Checks each beat against the oldest
  // prediction, then picks ready: steady, a rotating stall pattern, or coin
  // flips, with the mode picked anew at random. Twice in the run it holds off for
  // a long stretch so the internal queue fills and the input side backs up.
  // --------------------------------------------------------------------------
  plain_beat_t want;
  rx_mode_e    rx_mode    = RX_STEADY;
  int unsigned mode_left  = 0;
  int unsigned hold_left  = 0;
  int unsigned beats_out  = 0;
  logic [15:0] stall_pat  = 16'hffff;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      plain_if.ready <= 1'b0;
    end else begin
      if (plain_if.valid && plain_if.ready) begin
        if (plaintext_q.size() == 0) begin
          $error("unexpected plaintext beat: plain_char %02h message_done %0b",
                 plain_if.plain_char, plain_if.message_done);
          fail_count++;
        end else begin
          want = plaintext_q.pop_front();
          if (plain_if.plain_char !== want.ch) begin
            $error("plain_char: expected %02h, actual %02h", want.ch, plain_if.plain_char);
            fail_count++;
          end
          if (plain_if.message_done !== want.done) begin
            $error("message_done: expected %0b, actual %0b",
                   want.done, plain_if.message_done);
            fail_count++;
          end
        end
        beats_out++;
        if (beats_out == 300 || beats_out == 750) begin
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        plain_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(16, 96);
          stall_pat = 16'($urandom);
        end
        mode_left--;
        case (rx_mode)
          RX_STEADY: begin
            plain_if.ready <= 1'b1;
          end
          RX_PATTERN: begin
            stall_pat = {stall_pat[14:0], stall_pat[15]};
            plain_if.ready <= stall_pat[15];
          end
          default: begin
            plain_if.ready <= 1'($urandom_range(0, 1));
          end
        endcase
      end
    end
  end

  // Hang detector: no beat on either side for too long.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cipher_if.valid && cipher_if.ready) || (plain_if.valid && plain_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_beat(input logic [7:0] c, input logic eom);
    cipher_beat_t b;
    b.ch  = c;
    b.eom = eom;
    cipher_q.push_back(b);
  endtask

  // Register write; the shadow copy is updated with it. Only called with
  // nothing in flight.
  task automatic write_reg(input vds_cfg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_KEY_LENGTH: key_len_q = data[KEY_LEN_W-1:0];
      CFG_KEY_LOW:    key_lo_q  = data;
      CFG_KEY_HIGH:   key_hi_q  = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_key(input logic [KEY_LEN_W-1:0] len,
                          input logic [CFG_DATA_W-1:0] lo,
                          input logic [CFG_DATA_W-1:0] hi);
    write_reg(CFG_KEY_LENGTH, CFG_DATA_W'(len));
    write_reg(CFG_KEY_LOW, lo);
    write_reg(CFG_KEY_HIGH, hi);
  endtask

  // Wait until every beat is in and out, then let the pipe settle.
  task automatic drain(input int unsigned settle);
    while (cipher_q.size() != 0 || plaintext_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (settle) @(posedge clk_i);
  endtask

  // Mostly letters in both cases, some punctuation and spaces, a few raw bytes.
  function automatic logic [7:0] text_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      return 8'($urandom_range(CHAR_UPPER_A, CHAR_UPPER_Z));
    end else if (r < 75) begin
      return 8'($urandom_range(CHAR_LOWER_A, CHAR_LOWER_Z));
    end else if (r < 88) begin
      return 8'($urandom_range(32, 126));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Eight keyword bytes, mostly letters with the odd non-letter.
  function automatic logic [CFG_DATA_W-1:0] key_word();
    logic [CFG_DATA_W-1:0] w;
    int unsigned           r;
    w = '0;
    for (int i = 0; i < 8; i++) begin
      r = $urandom_range(0, 9);
      if (r < 4) begin
        w[i*8 +: 8] = 8'($urandom_range(CHAR_UPPER_A, CHAR_UPPER_Z));
      end else if (r < 8) begin
        w[i*8 +: 8] = 8'($urandom_range(CHAR_LOWER_A, CHAR_LOWER_Z));
      end else begin
        w[i*8 +: 8] = 8'($urandom);
      end
    end
    return w;
  endfunction

  // One message: usually text closed by end of message; sometimes cut off
  // without it, sometimes raw noise with stray end flags.
  task automatic queue_message(output int unsigned n);
    int unsigned kind;
    kind = $urandom_range(0, 9);
    n    = $urandom_range(1, 40);
    for (int unsigned i = 0; i < n; i++) begin
      if (kind == 0) begin
        queue_beat(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
      end else begin
        queue_beat(text_char(), (i == n - 1) && (kind != 1));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  int unsigned fed;
  int unsigned target;
  int unsigned n;
  int unsigned phase;
  logic [KEY_LEN_W-1:0]  len;
  logic [CFG_DATA_W-1:0] lo;
  logic [CFG_DATA_W-1:0] hi;

  initial begin
    rst_ni                   = 1'b0;
    cfg_we_i                 = 1'b0;
    cfg_idx_i                = CFG_KEY_LENGTH;
    cfg_wdata_i              = '0;
    cipher_if.valid          = 1'b0;
    cipher_if.cipher_char    = 8'h00;
    cipher_if.end_of_message = 1'b0;
    plain_if.ready           = 1'b0;
    key_len_q                = KEY_LEN_RESET;
    key_lo_q                 = KEY_CHARS_RESET;
    key_hi_q                 = KEY_CHARS_RESET;
    key_pos_q                = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset key is a single 'A': everything passes through. Letter edges,
    // their neighbors, and bytes at both ends of the range.
    queue_beat(8'h00, 1'b0);
    queue_beat(CHAR_UPPER_A, 1'b0);
    queue_beat(CHAR_LOWER_Z, 1'b0);
    queue_beat(CHAR_UPPER_A - 8'd1, 1'b0);
    queue_beat(CHAR_UPPER_Z + 8'd1, 1'b0);
    queue_beat(CHAR_LOWER_A - 8'd1, 1'b0);
    queue_beat(CHAR_LOWER_Z + 8'd1, 1'b0);
    queue_beat(8'hff, 1'b1);          // end flag on a non-letter
    drain(PIPE_SETTLE);

    // Zero length acts as one: Caesar with 'Z', the widest shift, so both
    // cases wrap around the alphabet.
    load_key('0, 64'h4141_4141_4141_415a, KEY_CHARS_RESET);
    queue_beat(CHAR_UPPER_A, 1'b0);
    queue_beat(CHAR_LOWER_Z, 1'b0);
    queue_beat(CHAR_LOWER_A, 1'b1);
    drain(PIPE_SETTLE);

    // Length past the limit saturates; key bytes mix cases and non-letters,
    // and a space in the text must not move the key.
    load_key('1, 64'h7a5b_4060_0061_5a41, 64'hff7b_4d6d_7a61_5a41);
    queue_beat(8'h51, 1'b0);          // Q
    queue_beat(8'h20, 1'b0);          // space
    queue_beat(8'h71, 1'b0);          // q
    queue_beat(8'h51, 1'b1);
    drain(PIPE_SETTLE);

    // Key position left past a lowered length falls back to key byte 0.
    load_key(KEY_LEN_W'(8), 64'h6867_6665_6463_6261, 64'h504f_4e4d_4c4b_4a49);
    repeat (5) queue_beat(8'h6d, 1'b0);
    drain(PIPE_SETTLE);
    write_reg(CFG_KEY_LENGTH, CFG_DATA_W'(3));
    queue_beat(8'h4d, 1'b0);
    queue_beat(8'h6d, 1'b1);
    drain(PIPE_SETTLE);

    // Random phases, each with its own key; the first few pin the extremes.
    fed   = 0;
    phase = 0;
    while (fed < RANDOM_BEATS) begin
      drain(PIPE_SETTLE);
      case (phase)
        0: begin
          len = '0;  lo = '0;  hi = '0;
        end
        1: begin
          len = '1;  lo = '1;  hi = '1;
        end
        2: begin
          len = KEY_LEN_W'(MAX_KEY_LETTERS);
          lo  = 64'h7a7a_7a7a_7a7a_7a7a;
          hi  = 64'h5a5a_5a5a_5a5a_5a5a;
        end
        3: begin
          len = KEY_LEN_W'(1);  lo = key_word();  hi = key_word();
        end
        default: begin
          len = KEY_LEN_W'($urandom_range(0, 31));
          lo  = key_word();
          hi  = key_word();
        end
      endcase
      load_key(len, lo, hi);
      target = fed + $urandom_range(120, 200);
      if (target > RANDOM_BEATS) begin
        target = RANDOM_BEATS;        // last phase stops near the total
      end
      while (fed < target) begin
        queue_message(n);
        fed += n;
      end
      phase++;
    end

    drain(8);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/vds_pkg.sv
hdl/vds_in_if.sv
hdl/vds_out_if.sv
hdl/vds_front.sv
hdl/vds_queue.sv
hdl/vds_back.sv
hdl/vigenere_decrypt_stream.sv
sim/tb_top.sv
